[rtl/tdh_pkg.sv]
// Package for the timer deadline heap: sizes, codes, structs shared by all files.
package tdh_pkg;

   localparam int NUM_TIMERS = 64;
   localparam int HEAP_DEPTH = 64;
   localparam int MAX_FIRES  = 64;
   localparam int ID_W       = 6;
   localparam int POS_W      = 6;
   localparam int CNT_W      = 7;
   localparam int TIME_W     = 64;
   localparam int CMD_W      = 3;

   localparam logic [CMD_W-1:0] CMD_ARM_AT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ARM_IN  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ARM_PER = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] key;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SLOT_RD, S_DETACH, S_MOVED, S_RISE_RD, S_RISE_CMP,
      S_SINK_RD, S_SINK_CMP, S_PLACE, S_ARM, S_ROOT_RD, S_ROOT_CHK, S_PER,
      S_REARM, S_NEXT_RD, S_NEXT, S_EMIT_RD, S_EMIT, S_WAIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_SLOT_RD, OP_DETACH, OP_MOVED, OP_RISE_RD, OP_RISE_CMP,
      OP_SINK_RD, OP_SINK_CMP, OP_PLACE, OP_ARM, OP_ROOT_RD, OP_ROOT_CHK, OP_PER,
      OP_REARM, OP_NEXT_RD, OP_NEXT, OP_EMIT_RD, OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      CTX_DETACH, CTX_PUSH, CTX_POP, CTX_REARM
   } ctx_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             id_armed;
      logic             detach_end;
      logic             rise_stop;
      logic             first;
      logic             sink_mode;
      logic             sink_stop;
      logic             full;
      logic             due;
      logic             pop_empty;
      logic             per_zero;
      logic             out_valid;
      logic             done;
   } stat_type;

endpackage

[rtl/tdh_if.sv]
// Valid/ready channel interfaces for command words and result words.
interface tdh_req_if;
   logic                         valid;
   logic                         ready;
   logic [tdh_pkg::CMD_W-1:0]    cmd;
   logic [tdh_pkg::ID_W-1:0]     timer_id;
   logic [tdh_pkg::TIME_W-1:0]   time_value;
   logic [tdh_pkg::TIME_W-1:0]   now;
   modport source (output valid, cmd, timer_id, time_value, now, input ready);
   modport sink   (input valid, cmd, timer_id, time_value, now, output ready);
endinterface

interface tdh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         fired;
   logic [tdh_pkg::ID_W-1:0]     fired_timer;
   logic                         last;
   logic                         accepted;
   logic                         new_head;
   logic [tdh_pkg::TIME_W-1:0]   next_deadline;
   modport source (output valid, fired, fired_timer, last, accepted, new_head,
                   next_deadline, input ready);
   modport sink   (input valid, fired, fired_timer, last, accepted, new_head,
                   next_deadline, output ready);
endinterface

[rtl/tdh_dp.sv]
// Datapath: heap, slot, period and fired-id memories with the sift registers.
module tdh_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  tdh_pkg::ctrl_type           ctrl,
   output tdh_pkg::stat_type           stat,
   input  logic [tdh_pkg::CMD_W-1:0]   req_cmd,
   input  logic [tdh_pkg::ID_W-1:0]    req_timer_id,
   input  logic [tdh_pkg::TIME_W-1:0]  req_time_value,
   input  logic [tdh_pkg::TIME_W-1:0]  req_now,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_fired,
   output logic [tdh_pkg::ID_W-1:0]    rsp_fired_timer,
   output logic                        rsp_last,
   output logic                        rsp_accepted,
   output logic                        rsp_new_head,
   output logic [tdh_pkg::TIME_W-1:0]  rsp_next_deadline
);

   // memories
   tdh_pkg::entry_type              heap_mem [tdh_pkg::HEAP_DEPTH];
   logic [tdh_pkg::POS_W-1:0]       slot_mem [tdh_pkg::NUM_TIMERS];
   logic [tdh_pkg::TIME_W-1:0]      per_mem  [tdh_pkg::NUM_TIMERS];
   logic [tdh_pkg::ID_W-1:0]        fifo_mem [tdh_pkg::MAX_FIRES];

   tdh_pkg::entry_type              rd_a_ff, rd_b_ff;
   logic [tdh_pkg::POS_W-1:0]       slot_q_ff;
   logic [tdh_pkg::TIME_W-1:0]      per_q_ff;
   logic [tdh_pkg::ID_W-1:0]        fifo_q_ff;

   // control and work registers
   logic [tdh_pkg::CMD_W-1:0]       cmd_ff;
   logic [tdh_pkg::ID_W-1:0]        id_ff;
   logic [tdh_pkg::TIME_W-1:0]      tv_ff, now_ff, d1_ff, next_ff;
   logic [tdh_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [tdh_pkg::POS_W-1:0]       pos_ff;
   tdh_pkg::entry_type              item_ff, popped_ff;
   logic                            sink_mode_ff, first_ff, acc_ff, head_ff, done_ff;
   logic [tdh_pkg::CNT_W-1:0]       nfired_ff, emit_ff;
   logic [tdh_pkg::NUM_TIMERS-1:0]  armed_ff;
   logic                            out_valid_ff;
   logic                            fired_ff, last_ff;
   logic [tdh_pkg::ID_W-1:0]        fired_id_ff;

   // combinational helpers
   logic [tdh_pkg::POS_W-1:0]       addr_a, addr_b, ppos;
   logic [tdh_pkg::CNT_W-1:0]       lidx, cnt_m1;
   logic [tdh_pkg::CNT_W:0]         ridx;
   logic                            wr_en;
   logic [tdh_pkg::POS_W-1:0]       wr_addr;
   tdh_pkg::entry_type              wr_data;
   logic                            rise_stop, l_ok, r_ok, due, last_word;
   logic [tdh_pkg::TIME_W-1:0]      l_best, rearm_dl, arm_dl;

   assign cnt_m1 = count_ff - 1'b1;
   assign ppos   = (pos_ff - 1'b1) >> 1;
   assign lidx   = {pos_ff, 1'b1};
   assign ridx   = {1'b0, pos_ff, 1'b0} + 8'd2;
   assign rise_stop = (pos_ff == '0) || (rd_a_ff.key <= item_ff.key);
   assign l_ok   = (lidx < count_ff) && (rd_a_ff.key < item_ff.key);
   assign l_best = l_ok ? rd_a_ff.key : item_ff.key;
   assign r_ok   = (ridx < {1'b0, count_ff}) && (rd_b_ff.key < l_best);
   assign due    = (count_ff != '0) && !nfired_ff[tdh_pkg::CNT_W-1] &&
                   (rd_a_ff.key <= now_ff);
   assign rearm_dl = (d1_ff <= now_ff) ? (now_ff + per_q_ff) : d1_ff;
   assign arm_dl = (cmd_ff == tdh_pkg::CMD_ARM_AT) ? tv_ff : (now_ff + tv_ff);
   assign last_word = (nfired_ff == '0) || (emit_ff + 1'b1 == nfired_ff);

   // pick heap read addresses and the one heap write of this cycle
   always_comb begin
      addr_a  = '0;
      addr_b  = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = item_ff;
      case (ctrl.op)
         tdh_pkg::OP_RISE_RD: begin
            addr_a = ppos;
         end
         tdh_pkg::OP_SINK_RD: begin
            addr_a = lidx[tdh_pkg::POS_W-1:0];
            addr_b = ridx[tdh_pkg::POS_W-1:0];
         end
         tdh_pkg::OP_ROOT_RD: begin
            addr_b = cnt_m1[tdh_pkg::POS_W-1:0];
         end
         tdh_pkg::OP_DETACH: begin
            addr_b = cnt_m1[tdh_pkg::POS_W-1:0];
         end
         tdh_pkg::OP_RISE_CMP: begin
            wr_en   = !rise_stop;
            wr_data = rd_a_ff;
         end
         tdh_pkg::OP_SINK_CMP: begin
            wr_en   = l_ok || r_ok;
            wr_data = r_ok ? rd_b_ff : rd_a_ff;
         end
         tdh_pkg::OP_PLACE: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // heap and slot memories
   always_ff @(posedge clock) begin
      rd_a_ff <= heap_mem[addr_a];
      rd_b_ff <= heap_mem[addr_b];
      if (wr_en) begin
         heap_mem[wr_addr]    <= wr_data;
         slot_mem[wr_data.id] <= wr_addr;
      end
      if (ctrl.op == tdh_pkg::OP_SLOT_RD) begin
         slot_q_ff <= slot_mem[id_ff];
      end
   end

   // period memory
   always_ff @(posedge clock) begin
      if (ctrl.op == tdh_pkg::OP_ARM) begin
         per_mem[id_ff] <= (cmd_ff == tdh_pkg::CMD_ARM_PER) ? tv_ff : '0;
      end
      if (ctrl.op == tdh_pkg::OP_ROOT_CHK) begin
         per_q_ff <= per_mem[rd_a_ff.id];
      end
   end

   // fired-id queue
   always_ff @(posedge clock) begin
      if (ctrl.op == tdh_pkg::OP_ROOT_CHK && due) begin
         fifo_mem[nfired_ff[tdh_pkg::POS_W-1:0]] <= rd_a_ff.id;
      end
      if (ctrl.op == tdh_pkg::OP_EMIT_RD) begin
         fifo_q_ff <= fifo_mem[emit_ff[tdh_pkg::POS_W-1:0]];
      end
   end

   // heap count
   always_comb begin
      count_in = count_ff;
      case (ctrl.op)
         tdh_pkg::OP_DETACH: count_in = cnt_m1;
         tdh_pkg::OP_ROOT_CHK: begin
            if (due) begin
               count_in = cnt_m1;
            end
         end
         tdh_pkg::OP_ARM: begin
            if (!count_ff[tdh_pkg::CNT_W-1]) begin
               count_in = count_ff + 1'b1;
            end
         end
         tdh_pkg::OP_REARM: count_in = count_ff + 1'b1;
         default: begin
         end
      endcase
   end

   // control state: count, armed bits, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         armed_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (ctrl.op == tdh_pkg::OP_DETACH) begin
            armed_ff[id_ff] <= 1'b0;
         end
         if (ctrl.op == tdh_pkg::OP_ROOT_CHK && due) begin
            armed_ff[rd_a_ff.id] <= 1'b0;
         end
         if (ctrl.op == tdh_pkg::OP_PLACE) begin
            armed_ff[item_ff.id] <= 1'b1;
         end
         if (ctrl.op == tdh_pkg::OP_EMIT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      case (ctrl.op)
         tdh_pkg::OP_LOAD: begin
            cmd_ff    <= req_cmd;
            id_ff     <= req_timer_id;
            tv_ff     <= req_time_value;
            now_ff    <= req_now;
            nfired_ff <= '0;
            acc_ff    <= 1'b0;
            head_ff   <= 1'b0;
         end
         tdh_pkg::OP_DETACH: begin
            pos_ff <= slot_q_ff;
         end
         tdh_pkg::OP_MOVED: begin
            item_ff      <= rd_b_ff;
            sink_mode_ff <= 1'b1;
            first_ff     <= 1'b1;
         end
         tdh_pkg::OP_RISE_CMP: begin
            if (!rise_stop) begin
               pos_ff   <= ppos;
               first_ff <= 1'b0;
            end
         end
         tdh_pkg::OP_SINK_CMP: begin
            if (r_ok) begin
               pos_ff <= ridx[tdh_pkg::POS_W-1:0];
            end else if (l_ok) begin
               pos_ff <= lidx[tdh_pkg::POS_W-1:0];
            end
         end
         tdh_pkg::OP_PLACE: begin
            if (pos_ff == '0 && !sink_mode_ff && cmd_ff != tdh_pkg::CMD_TICK) begin
               head_ff <= 1'b1;
            end
         end
         tdh_pkg::OP_ARM: begin
            item_ff      <= '{id: id_ff, key: arm_dl};
            pos_ff       <= count_ff[tdh_pkg::POS_W-1:0];
            sink_mode_ff <= 1'b0;
            first_ff     <= 1'b1;
            acc_ff       <= !count_ff[tdh_pkg::CNT_W-1];
         end
         tdh_pkg::OP_ROOT_CHK: begin
            if (due) begin
               nfired_ff <= nfired_ff + 1'b1;
               popped_ff <= rd_a_ff;
               item_ff   <= rd_b_ff;
               pos_ff    <= '0;
            end
         end
         tdh_pkg::OP_PER: begin
            d1_ff <= popped_ff.key + per_q_ff;
         end
         tdh_pkg::OP_REARM: begin
            item_ff      <= '{id: popped_ff.id, key: rearm_dl};
            pos_ff       <= count_ff[tdh_pkg::POS_W-1:0];
            sink_mode_ff <= 1'b0;
            first_ff     <= 1'b1;
         end
         tdh_pkg::OP_NEXT: begin
            next_ff <= (count_ff != '0) ? rd_a_ff.key : '1;
            emit_ff <= '0;
         end
         tdh_pkg::OP_EMIT: begin
            fired_ff    <= (nfired_ff != '0);
            fired_id_ff <= (nfired_ff != '0) ? fifo_q_ff : '0;
            last_ff     <= last_word;
            done_ff     <= last_word;
            emit_ff     <= emit_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // status back to the controller
   always_comb begin
      stat.cmd        = cmd_ff;
      stat.id_armed   = armed_ff[id_ff];
      stat.detach_end = ({1'b0, slot_q_ff} == cnt_m1);
      stat.rise_stop  = rise_stop;
      stat.first      = first_ff;
      stat.sink_mode  = sink_mode_ff;
      stat.sink_stop  = !(l_ok || r_ok);
      stat.full       = count_ff[tdh_pkg::CNT_W-1];
      stat.due        = due;
      stat.pop_empty  = (cnt_m1 == '0);
      stat.per_zero   = (per_q_ff == '0);
      stat.out_valid  = out_valid_ff;
      stat.done       = done_ff;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_fired         = fired_ff;
   assign rsp_fired_timer   = fired_id_ff;
   assign rsp_last          = last_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_new_head      = head_ff;
   assign rsp_next_deadline = next_ff;

endmodule

[rtl/tdh_ctrl.sv]
// Controller: sequences detach, insert, sift, pop and result output steps.
module tdh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tdh_pkg::stat_type   stat,
   output tdh_pkg::ctrl_type   ctrl
);

   tdh_pkg::state_type state_ff, state_in;
   tdh_pkg::ctx_type   ctx_ff, ctx_in;

   // hold state and sift context
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdh_pkg::S_IDLE;
         ctx_ff   <= tdh_pkg::CTX_PUSH;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
      end
   end

   // next state and datapath op
   always_comb begin
      state_in  = state_ff;
      ctx_in    = ctx_ff;
      ctrl.op   = tdh_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         tdh_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.op  = tdh_pkg::OP_LOAD;
               state_in = tdh_pkg::S_DISPATCH;
            end
         end
         tdh_pkg::S_DISPATCH: begin
            case (stat.cmd)
               tdh_pkg::CMD_ARM_AT, tdh_pkg::CMD_ARM_IN, tdh_pkg::CMD_ARM_PER: begin
                  state_in = stat.id_armed ? tdh_pkg::S_SLOT_RD : tdh_pkg::S_ARM;
               end
               tdh_pkg::CMD_CANCEL: begin
                  state_in = stat.id_armed ? tdh_pkg::S_SLOT_RD : tdh_pkg::S_NEXT_RD;
               end
               tdh_pkg::CMD_TICK: state_in = tdh_pkg::S_ROOT_RD;
               default: state_in = tdh_pkg::S_NEXT_RD;
            endcase
         end
         tdh_pkg::S_SLOT_RD: begin
            ctrl.op  = tdh_pkg::OP_SLOT_RD;
            ctx_in   = tdh_pkg::CTX_DETACH;
            state_in = tdh_pkg::S_DETACH;
         end
         tdh_pkg::S_DETACH: begin
            ctrl.op = tdh_pkg::OP_DETACH;
            if (!stat.detach_end) begin
               state_in = tdh_pkg::S_MOVED;
            end else if (stat.cmd == tdh_pkg::CMD_CANCEL) begin
               state_in = tdh_pkg::S_NEXT_RD;
            end else begin
               state_in = tdh_pkg::S_ARM;
            end
         end
         tdh_pkg::S_MOVED: begin
            ctrl.op  = tdh_pkg::OP_MOVED;
            state_in = tdh_pkg::S_RISE_RD;
         end
         tdh_pkg::S_RISE_RD: begin
            ctrl.op  = tdh_pkg::OP_RISE_RD;
            state_in = tdh_pkg::S_RISE_CMP;
         end
         tdh_pkg::S_RISE_CMP: begin
            ctrl.op = tdh_pkg::OP_RISE_CMP;
            if (!stat.rise_stop) begin
               state_in = tdh_pkg::S_RISE_RD;
            end else if (stat.sink_mode && stat.first) begin
               state_in = tdh_pkg::S_SINK_RD;
            end else begin
               state_in = tdh_pkg::S_PLACE;
            end
         end
         tdh_pkg::S_SINK_RD: begin
            ctrl.op  = tdh_pkg::OP_SINK_RD;
            state_in = tdh_pkg::S_SINK_CMP;
         end
         tdh_pkg::S_SINK_CMP: begin
            ctrl.op  = tdh_pkg::OP_SINK_CMP;
            state_in = stat.sink_stop ? tdh_pkg::S_PLACE : tdh_pkg::S_SINK_RD;
         end
         tdh_pkg::S_PLACE: begin
            ctrl.op = tdh_pkg::OP_PLACE;
            case (ctx_ff)
               tdh_pkg::CTX_DETACH: begin
                  state_in = (stat.cmd == tdh_pkg::CMD_CANCEL) ?
                             tdh_pkg::S_NEXT_RD : tdh_pkg::S_ARM;
               end
               tdh_pkg::CTX_PUSH:  state_in = tdh_pkg::S_NEXT_RD;
               tdh_pkg::CTX_POP:   state_in = tdh_pkg::S_PER;
               tdh_pkg::CTX_REARM: state_in = tdh_pkg::S_ROOT_RD;
               default:            state_in = tdh_pkg::S_NEXT_RD;
            endcase
         end
         tdh_pkg::S_ARM: begin
            ctrl.op  = tdh_pkg::OP_ARM;
            ctx_in   = tdh_pkg::CTX_PUSH;
            state_in = stat.full ? tdh_pkg::S_NEXT_RD : tdh_pkg::S_RISE_RD;
         end
         tdh_pkg::S_ROOT_RD: begin
            ctrl.op  = tdh_pkg::OP_ROOT_RD;
            state_in = tdh_pkg::S_ROOT_CHK;
         end
         tdh_pkg::S_ROOT_CHK: begin
            ctrl.op = tdh_pkg::OP_ROOT_CHK;
            ctx_in  = tdh_pkg::CTX_POP;
            if (!stat.due) begin
               state_in = tdh_pkg::S_NEXT_RD;
            end else if (stat.pop_empty) begin
               state_in = tdh_pkg::S_PER;
            end else begin
               state_in = tdh_pkg::S_SINK_RD;
            end
         end
         tdh_pkg::S_PER: begin
            ctrl.op  = tdh_pkg::OP_PER;
            state_in = stat.per_zero ? tdh_pkg::S_ROOT_RD : tdh_pkg::S_REARM;
         end
         tdh_pkg::S_REARM: begin
            ctrl.op  = tdh_pkg::OP_REARM;
            ctx_in   = tdh_pkg::CTX_REARM;
            state_in = tdh_pkg::S_RISE_RD;
         end
         tdh_pkg::S_NEXT_RD: begin
            ctrl.op  = tdh_pkg::OP_NEXT_RD;
            state_in = tdh_pkg::S_NEXT;
         end
         tdh_pkg::S_NEXT: begin
            ctrl.op  = tdh_pkg::OP_NEXT;
            state_in = tdh_pkg::S_EMIT_RD;
         end
         tdh_pkg::S_EMIT_RD: begin
            ctrl.op  = tdh_pkg::OP_EMIT_RD;
            state_in = tdh_pkg::S_EMIT;
         end
         tdh_pkg::S_EMIT: begin
            ctrl.op  = tdh_pkg::OP_EMIT;
            state_in = tdh_pkg::S_WAIT;
         end
         tdh_pkg::S_WAIT: begin
            if (!stat.out_valid) begin
               state_in = stat.done ? tdh_pkg::S_IDLE : tdh_pkg::S_EMIT_RD;
            end
         end
         default: state_in = tdh_pkg::S_IDLE;
      endcase
   end

endmodule

[rtl/timer_deadline_heap.sv]
// Timer deadline heap: one command word in, one or more result words out.
// Each heap level is a registered read followed by a compare and move. Each
// result word is read from the fired-id queue, registered and held until taken.
// One command word is in flight at a time; the next is taken after its last result.
// Reset clears the controller, the heap count and the in-heap bits.
module timer_deadline_heap (
   input  logic         clock,
   input  logic         reset,
   tdh_req_if.sink      req,
   tdh_rsp_if.source    rsp
);

   tdh_pkg::ctrl_type ctrl;
   tdh_pkg::stat_type stat;

   tdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   tdh_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_cmd           (req.cmd),
      .req_timer_id      (req.timer_id),
      .req_time_value    (req.time_value),
      .req_now           (req.now),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_fired         (rsp.fired),
      .rsp_fired_timer   (rsp.fired_timer),
      .rsp_last          (rsp.last),
      .rsp_accepted      (rsp.accepted),
      .rsp_new_head      (rsp.new_head),
      .rsp_next_deadline (rsp.next_deadline)
   );

   // no new command word while a result word is pending
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("command taken while result pending");

   // a word that reports no fired timer is the only word of its command
   a_nofire_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.fired |-> rsp.last && rsp.fired_timer == '0)
      else $error("non-fire result not single");

   // head refresh only on an accepted arm
   a_head_acc: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.new_head |-> rsp.accepted && !rsp.fired)
      else $error("new_head without accepted arm");

endmodule

[test/tdh_tb_if.sv]
// Shared testbench types: field types and the command and result word layouts.
package tdh_tb_pkg;

   typedef logic [tdh_pkg::CMD_W-1:0]  cmd_type;
   typedef logic [tdh_pkg::ID_W-1:0]   id_type;
   typedef logic [tdh_pkg::TIME_W-1:0] time_type;

   typedef struct packed {
      logic       fired;
      id_type     fired_timer;
      logic       last;
      logic       accepted;
      logic       new_head;
      time_type   next_deadline;
   } result_word_type;

   typedef struct packed {
      cmd_type    cmd;
      id_type     timer_id;
      time_type   time_value;
      time_type   now;
   } command_word_type;
endpackage

[test/testbench.sv]
// Testbench for the timer deadline heap: directed and random commands against a heap model.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 20000;
   localparam tdh_tb_pkg::time_type ALL_ONES = '1;
   localparam tdh_tb_pkg::cmd_type CMD_BAD5 = 3'd5;
   localparam tdh_tb_pkg::cmd_type CMD_BAD6 = 3'd6;
   localparam tdh_tb_pkg::cmd_type CMD_BAD7 = 3'd7;

   logic clock = 0;
   logic reset = 1;
   tdh_req_if req ();
   tdh_rsp_if rsp ();

   timer_deadline_heap dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial forever #5 clock = ~clock;

   // model state
   tdh_tb_pkg::id_type   heap_ids [tdh_pkg::HEAP_DEPTH];
   int                   heap_size;
   tdh_tb_pkg::time_type deadline_of [tdh_pkg::NUM_TIMERS];
   tdh_tb_pkg::time_type period_of [tdh_pkg::NUM_TIMERS];
   int                   pos_of [tdh_pkg::NUM_TIMERS];
   bit                   armed [tdh_pkg::NUM_TIMERS];

   tdh_tb_pkg::result_word_type expected_words [$];
   int  errors = 0;
   int  words_seen = 0;
   int  fires_seen = 0;
   int  idle_count = 0;
   bit  rsp_stall_on = 1;

   function automatic tdh_tb_pkg::time_type key_of(int p);
      return deadline_of[heap_ids[p]];
   endfunction

   function automatic void place(int p, tdh_tb_pkg::id_type id);
      heap_ids[p] = id;
      pos_of[id] = p;
   endfunction

   function automatic void swap_slots(int a, int b);
      tdh_tb_pkg::id_type ta;
      ta = heap_ids[a];
      place(a, heap_ids[b]);
      place(b, ta);
   endfunction

   function automatic void sift_up(int p);
      int up;
      while (p > 0) begin
         up = (p - 1) / 2;
         if (key_of(up) <= key_of(p)) break;
         swap_slots(p, up);
         p = up;
      end
   endfunction

   function automatic void sift_down(int p);
      int l, r, best;
      forever begin
         l = 2 * p + 1;
         r = 2 * p + 2;
         best = p;
         if (l < heap_size && key_of(l) < key_of(best)) best = l;
         if (r < heap_size && key_of(r) < key_of(best)) best = r;
         if (best == p) break;
         swap_slots(p, best);
         p = best;
      end
   endfunction

   function automatic bit add_to_heap(tdh_tb_pkg::id_type id);
      if (heap_size >= tdh_pkg::HEAP_DEPTH) return 0;
      place(heap_size, id);
      heap_size++;
      armed[id] = 1;
      sift_up(heap_size - 1);
      return 1;
   endfunction

   function automatic void heap_remove(int p);
      armed[heap_ids[p]] = 0;
      heap_size--;
      if (p == heap_size) return;
      place(p, heap_ids[heap_size]);
      if (p > 0 && key_of((p - 1) / 2) > key_of(p)) sift_up(p);
      else sift_down(p);
   endfunction

   function automatic void unlink(tdh_tb_pkg::id_type id);
      if (armed[id] && pos_of[id] < heap_size && heap_ids[pos_of[id]] == id)
         heap_remove(pos_of[id]);
      armed[id] = 0;
   endfunction

   // compute the result words of one command and queue them
   function automatic void predict_command(tdh_tb_pkg::command_word_type c);
      tdh_tb_pkg::id_type          popped [$];
      tdh_tb_pkg::id_type          t;
      tdh_tb_pkg::time_type        d;
      tdh_tb_pkg::time_type        nd;
      bit                          acc, head;
      tdh_tb_pkg::result_word_type w;
      int                          n;
      acc = 0;
      head = 0;
      if (c.cmd == tdh_pkg::CMD_ARM_AT || c.cmd == tdh_pkg::CMD_ARM_IN ||
          c.cmd == tdh_pkg::CMD_ARM_PER) begin
         unlink(c.timer_id);
         deadline_of[c.timer_id] = (c.cmd == tdh_pkg::CMD_ARM_AT) ? c.time_value
                                                                   : c.now + c.time_value;
         period_of[c.timer_id] = (c.cmd == tdh_pkg::CMD_ARM_PER) ? c.time_value : '0;
         acc = add_to_heap(c.timer_id);
         head = acc && heap_ids[0] == c.timer_id;
      end else if (c.cmd == tdh_pkg::CMD_CANCEL) begin
         unlink(c.timer_id);
         deadline_of[c.timer_id] = '0;
         period_of[c.timer_id] = '0;
      end else if (c.cmd == tdh_pkg::CMD_TICK) begin
         while (heap_size > 0 && popped.size() < tdh_pkg::MAX_FIRES &&
                key_of(0) <= c.now) begin
            t = heap_ids[0];
            heap_remove(0);
            if (period_of[t] != 0) begin
               d = deadline_of[t] + period_of[t];
               if (d <= c.now) d = c.now + period_of[t];
               deadline_of[t] = d;
               void'(add_to_heap(t));
            end else begin
               deadline_of[t] = '0;
            end
            popped.push_back(t);
         end
      end
      nd = (heap_size > 0) ? key_of(0) : ALL_ONES;
      n = (popped.size() > 0) ? popped.size() : 1;
      for (int k = 0; k < n; k++) begin
         w.fired = popped.size() > 0;
         w.fired_timer = (popped.size() > 0) ? popped[k] : '0;
         w.last = (k == n - 1);
         w.accepted = acc;
         w.new_head = head;
         w.next_deadline = nd;
         expected_words.push_back(w);
      end
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // send one word, predict on acceptance
   task automatic send_command(tdh_tb_pkg::command_word_type c, bit with_gaps = 1);
      int g;
      g = with_gaps ? gap_len() : 0;
      // drop valid over an idle gap; a back-to-back word replaces the old one
      if (g > 0) begin
         req.valid <= 0;
         repeat (g) @(negedge clock);
      end
      req.valid <= 1;
      req.cmd <= c.cmd;
      req.timer_id <= c.timer_id;
      req.time_value <= c.time_value;
      req.now <= c.now;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_command(c);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic tdh_tb_pkg::command_word_type make_cmd(
      tdh_tb_pkg::cmd_type cmd, tdh_tb_pkg::id_type id,
      tdh_tb_pkg::time_type tv, tdh_tb_pkg::time_type nw);
      tdh_tb_pkg::command_word_type c;
      c.cmd = cmd;
      c.timer_id = id;
      c.time_value = tv;
      c.now = nw;
      return c;
   endfunction

   function automatic tdh_tb_pkg::time_type rand_time();
      return {$urandom, $urandom};
   endfunction

   // edge values, every command, zero period, bad codes
   task automatic test_directed();
      send_command(make_cmd(tdh_pkg::CMD_TICK, 0, 0, 0));
      send_command(make_cmd(tdh_pkg::CMD_CANCEL, 63, 0, 0));
      send_command(make_cmd(tdh_pkg::CMD_ARM_AT, 0, ALL_ONES, 0));
      send_command(make_cmd(tdh_pkg::CMD_ARM_AT, 63, 0, ALL_ONES));
      send_command(make_cmd(tdh_pkg::CMD_ARM_IN, 5, 100, ALL_ONES - 10));
      send_command(make_cmd(tdh_pkg::CMD_ARM_PER, 7, 0, 50));
      send_command(make_cmd(tdh_pkg::CMD_ARM_PER, 9, 30, 0));
      send_command(make_cmd(tdh_pkg::CMD_ARM_AT, 63, 20, 0));
      send_command(make_cmd(tdh_pkg::CMD_TICK, 0, 0, 60));
      send_command(make_cmd(tdh_pkg::CMD_ARM_PER, 11, 64'h8000_0000_0000_0000,
                            ALL_ONES - 1));
      send_command(make_cmd(CMD_BAD5, 3, 1, 2));
      send_command(make_cmd(CMD_BAD7, 63, ALL_ONES, ALL_ONES));
      send_command(make_cmd(tdh_pkg::CMD_CANCEL, 9, 0, 0));
      send_command(make_cmd(tdh_pkg::CMD_TICK, 42, ALL_ONES, ALL_ONES));
      send_command(make_cmd(tdh_pkg::CMD_TICK, 0, 0, ALL_ONES));
      wait_drained();
   endtask

   // fill all 64 timers, re-arm one (detach+insert on full heap), then fire everything
   task automatic test_full_heap();
      for (int i = 0; i < tdh_pkg::NUM_TIMERS; i++)
         send_command(make_cmd(tdh_pkg::CMD_ARM_AT, tdh_tb_pkg::id_type'(i),
                               tdh_tb_pkg::time_type'(1000 + $urandom_range(0, 500)), 0));
      send_command(make_cmd(tdh_pkg::CMD_ARM_IN, 17, 3, 1000));
      send_command(make_cmd(tdh_pkg::CMD_TICK, 0, 0, 1300));
      send_command(make_cmd(tdh_pkg::CMD_TICK, 0, 0, 2000));
      wait_drained();
   endtask

   // random mix of arms, cancels, ticks and bad codes on a moving clock
   task automatic test_random(int count);
      tdh_tb_pkg::time_type t_now;
      tdh_tb_pkg::command_word_type c;
      int sel;
      int bad;
      t_now = rand_time();
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         c = make_cmd(tdh_pkg::CMD_TICK, tdh_tb_pkg::id_type'($urandom_range(0, 63)),
                      rand_time(), t_now);
         if (sel < 20) begin
            c.cmd = tdh_pkg::CMD_ARM_AT;
            c.time_value = ($urandom_range(0, 9) == 0) ? rand_time()
                           : t_now + tdh_tb_pkg::time_type'($urandom_range(0, 400));
         end else if (sel < 40) begin
            c.cmd = tdh_pkg::CMD_ARM_IN;
            if ($urandom_range(0, 9) != 0)
               c.time_value = tdh_tb_pkg::time_type'($urandom_range(0, 400));
         end else if (sel < 55) begin
            c.cmd = tdh_pkg::CMD_ARM_PER;
            if ($urandom_range(0, 9) != 0)
               c.time_value = tdh_tb_pkg::time_type'($urandom_range(0, 200));
         end else if (sel < 65) begin
            c.cmd = tdh_pkg::CMD_CANCEL;
         end else if (sel < 67) begin
            bad = $urandom_range(0, 2);
            c.cmd = (bad == 0) ? CMD_BAD5 : (bad == 1) ? CMD_BAD6 : CMD_BAD7;
         end else begin
            t_now = t_now + tdh_tb_pkg::time_type'($urandom_range(0, 150));
            c.now = t_now;
         end
         if ($urandom_range(0, 30) == 0) t_now = rand_time();
         send_command(c, i % 60 < 45);
         // at the halfway point, hold off until all results are back
         if (i == count / 2) wait_drained();
      end
      wait_drained();
   endtask

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      tdh_tb_pkg::result_word_type w, e;
      if (!reset && rsp.valid && rsp.ready) begin
         w = {rsp.fired, rsp.fired_timer, rsp.last, rsp.accepted, rsp.new_head,
              rsp.next_deadline};
         words_seen++;
         if (rsp.fired) fires_seen++;
         if (expected_words.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = expected_words.pop_front();
            if (w.fired !== e.fired) begin
               $error("fired exp %0d got %0d", e.fired, w.fired); errors++;
            end
            if (w.fired_timer !== e.fired_timer) begin
               $error("fired_timer exp %0d got %0d", e.fired_timer, w.fired_timer);
               errors++;
            end
            if (w.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, w.last); errors++;
            end
            if (w.accepted !== e.accepted) begin
               $error("accepted exp %0d got %0d", e.accepted, w.accepted); errors++;
            end
            if (w.new_head !== e.new_head) begin
               $error("new_head exp %0d got %0d", e.new_head, w.new_head); errors++;
            end
            if (w.next_deadline !== e.next_deadline) begin
               $error("next_deadline exp %h got %h", e.next_deadline, w.next_deadline);
               errors++;
            end
         end
      end
   end

   // random backpressure on the result side
   initial begin
      int g;
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (!rsp_stall_on || $urandom_range(0, 2) != 0) rsp.ready <= 1;
         else begin
            rsp.ready <= 0;
            g = gap_len() + 1;
            repeat (g) @(negedge clock);
            rsp.ready <= 1;
         end
         if ($urandom_range(0, 199) == 0) rsp_stall_on = !rsp_stall_on;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count > WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      req.valid = 0;
      req.cmd = tdh_pkg::CMD_TICK;
      req.timer_id = '0;
      req.time_value = '0;
      req.now = '0;
      for (int i = 0; i < tdh_pkg::NUM_TIMERS; i++) begin
         deadline_of[i] = '0;
         period_of[i] = '0;
         pos_of[i] = 0;
         armed[i] = 0;
      end
      heap_size = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_full_heap();
      test_random(230);
      $display("Covered directed edge cases, a full heap and random traffic: %0d words, %0d fires.",
               words_seen, fires_seen);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
